[rtl/insort_pkg.sv]
// ----------------------------------------------------------------------------
// insort_pkg: shared types and constants for the insertion sorter
// Capacity, widths and the structs passed along the cell chain.
// ----------------------------------------------------------------------------
package insort_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                      ins;
    logic                      shift;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

  // what one cell shows to its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      gt;
    logic signed [VALUE_W-1:0] value;
  } cell_link_t;

endpackage

[rtl/insort_cell.sv]
// ----------------------------------------------------------------------------
// insort_cell: one slot of the sorting chain
// Holds one element; on insert it keeps, takes the new element or takes its
// lower neighbor's element; on unload it takes its upper neighbor's element.
// ----------------------------------------------------------------------------
module insort_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  insort_pkg::cell_ctrl_t ctrl,
  input  insort_pkg::cell_link_t from_prev,
  input  insort_pkg::cell_link_t from_next,
  output insort_pkg::cell_link_t link
);
  import insort_pkg::*;

  logic                      valid;
  logic signed [VALUE_W-1:0] value;
  logic                      gt;

  // empty slots count as greater than anything; ties keep older elements first
  assign gt = !valid || (value > ctrl.value);

  assign link.valid = valid;
  assign link.gt    = gt;
  assign link.value = value;

  // slot update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= from_next.valid;
    end else if (ctrl.ins && gt) begin
      valid <= valid | from_prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= from_next.value;
    end else if (ctrl.ins && gt) begin
      value <= from_prev.gt ? from_prev.value : ctrl.value;
    end
  end

endmodule

[rtl/insertion_sorter.sv]
// ----------------------------------------------------------------------------
// insertion_sorter: streaming signed insertion sorter over a chain of cells
// Load: one element per cycle, placed in the cell chain in the accept cycle,
// or dropped when full. Unload: after the final item, results for each held
// element back to back; busy is high until the last result. Sync reset.
// ----------------------------------------------------------------------------
module insertion_sorter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [insort_pkg::VALUE_W-1:0] value,
  input  logic                                 final_item,
  output logic                                 strobe,
  output logic signed [insort_pkg::VALUE_W-1:0] sorted_value,
  output logic                                 last_out,
  output logic                                 overflow
);
  import insort_pkg::*;

  typedef enum logic {ST_LOAD, ST_EMIT} state_t;

  state_t             state;
  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] held_count_next;
  logic               dropped_flag;
  logic               first;
  logic               accept;
  logic               full;
  cell_ctrl_t         ctrl;
  cell_link_t         links [MAX_ITEMS];
  cell_link_t         prev_links [MAX_ITEMS];
  cell_link_t         next_links [MAX_ITEMS];

  assign busy   = (state == ST_EMIT);
  assign accept = start && !busy;
  assign full   = (held_count == COUNT_W'(MAX_ITEMS));

  // broadcast control
  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = busy;
  assign ctrl.value = value;

  assign held_count_next = held_count + COUNT_W'(ctrl.ins);

  // neighbor wiring, chain ends tied off
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (i == 0) begin
        prev_links[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
      end else begin
        prev_links[i] = links[i-1];
      end
      if (i == MAX_ITEMS - 1) begin
        next_links[i] = '{valid: 1'b0, gt: 1'b1, value: '0};
      end else begin
        next_links[i] = links[i+1];
      end
    end
  end

  // cell chain
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    insort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .from_prev (prev_links[g]),
      .from_next (next_links[g]),
      .link      (links[g])
    );
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      held_count   <= '0;
      dropped_flag <= 1'b0;
      first        <= 1'b0;
      strobe       <= 1'b0;
      last_out     <= 1'b0;
      overflow     <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      last_out <= 1'b0;
      overflow <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            held_count <= held_count_next;
            if (full) begin
              dropped_flag <= 1'b1;
            end
            if (final_item) begin
              state <= ST_EMIT;
              first <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          strobe       <= 1'b1;
          sorted_value <= links[0].value;
          last_out     <= (held_count == COUNT_W'(1));
          overflow     <= first && dropped_flag;
          first        <= 1'b0;
          held_count   <= held_count - COUNT_W'(1);
          if (held_count == COUNT_W'(1)) begin
            state        <= ST_LOAD;
            dropped_flag <= 1'b0;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // checks
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_EMIT))
    else $error("result without unload");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    last_out |-> (strobe && !busy))
    else $error("last result but still busy");

  a_overflow_first: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (strobe && $past(first)))
    else $error("overflow flag off the first result");

  a_final_unloads: assert property (@(posedge clk) disable iff (rst)
    (accept && final_item) |=> busy)
    else $error("final transaction did not start unload");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (held_count != '0))
    else $error("unload with empty store");

endmodule

[tb/insertion_sorter_test.sv]
// ----------------------------------------------------------------------------
// insertion_sorter_test: self-checking bench for the streaming insertion sorter
// Feeds sets of signed 32-bit elements through the command interface with
// random sender gaps. An in-bench ordering model predicts each emitted set
// (ascending order, stable among equal values, capacity drops, overflow flag).
// A monitor checks every strobed result field by field against that model.
// ----------------------------------------------------------------------------
module insertion_sorter_test;
  import insort_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 450;
  localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      final_item;
  } element_t;

  typedef struct {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;
  } sorted_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [VALUE_W-1:0] value = '0;
  logic final_item = 1'b0;
  logic busy;
  logic strobe;
  logic signed [VALUE_W-1:0] sorted_value;
  logic last_out;
  logic overflow;

  // stimulus and expected results
  element_t element_feed[$];
  sorted_t  sorted_expect[$];

  // ordering model state
  logic signed [VALUE_W-1:0] model_store [MAX_ITEMS];
  int model_count = 0;
  logic model_dropped = 1'b0;

  // bookkeeping
  int errors = 0;
  int results_seen = 0;
  int sets_done = 0;
  int overflow_sets = 0;
  int full_sets = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  logic next_start;
  element_t next_item;

  insertion_sorter uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .final_item   (final_item),
    .strobe       (strobe),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
  );

  // clock, period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // insert one accepted element into the model, emit the set on a final item
  task automatic place_element(input logic signed [VALUE_W-1:0] v, input logic fin);
    int pos;
    sorted_t res;
    pos = model_count;
    if (model_count >= MAX_ITEMS) begin
      model_dropped = 1'b1;
    end else begin
      // newer element goes after equal older ones
      while (pos > 0 && model_store[pos-1] > v) begin
        model_store[pos] = model_store[pos-1];
        pos--;
      end
      model_store[pos] = v;
      model_count++;
    end
    if (fin) begin
      for (int k = 0; k < model_count; k++) begin
        res.sorted_value = model_store[k];
        res.last_out     = (k == model_count - 1);
        res.overflow     = (k == 0) ? model_dropped : 1'b0;
        sorted_expect.push_back(res);
      end
      sets_done++;
      if (model_dropped) overflow_sets++;
      if (model_count == MAX_ITEMS) full_sets++;
      model_count   = 0;
      model_dropped = 1'b0;
    end
  endtask

  // sender gap: mostly none, some short, a few long, with gap-free bursts
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // element values: extremes, a narrow band for ties, full range
  function automatic logic signed [VALUE_W-1:0] draw_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      1, 2: v = $signed($urandom_range(0, 8)) - 4;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_element(input logic signed [VALUE_W-1:0] v, input logic fin);
    element_t e;
    e.value      = v;
    e.final_item = fin;
    element_feed.push_back(e);
  endtask

  // driver: one transaction per accept, gaps drawn between items
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        place_element(value, final_item);
        next_start = 1'b0;
        gap_left   = draw_gap();
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (element_feed.size() > 0) begin
          next_item  = element_feed.pop_front();
          next_start = 1'b1;
          value      <= next_item.value;
          final_item <= next_item.final_item;
        end
      end
      start <= next_start;
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      results_seen++;
      if (sorted_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d last=%0b overflow=%0b",
                 $time, sorted_value, last_out, overflow);
      end else begin
        if (sorted_value !== sorted_expect[0].sorted_value) begin
          errors++;
          $display("%0t: sorted_value expected %0d actual %0d",
                   $time, sorted_expect[0].sorted_value, sorted_value);
        end
        if (last_out !== sorted_expect[0].last_out) begin
          errors++;
          $display("%0t: last_out expected %0b actual %0b",
                   $time, sorted_expect[0].last_out, last_out);
        end
        if (overflow !== sorted_expect[0].overflow) begin
          errors++;
          $display("%0t: overflow expected %0b actual %0b",
                   $time, sorted_expect[0].overflow, overflow);
        end
        void'(sorted_expect.pop_front());
      end
    end
  end

  // watchdog on cycles with no accepted transaction and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d items pending, %0d results outstanding",
               $time, element_feed.size(), sorted_expect.size());
      $display("insertion_sorter regression: fail");
      $finish;
    end
  end

  initial begin
    int len;
    int total;

    // directed: single element set at the most negative value
    queue_element(MOST_NEG, 1'b1);
    // extremes of the value range
    queue_element(MOST_POS, 1'b0);
    queue_element(MOST_NEG, 1'b0);
    queue_element(0, 1'b0);
    queue_element(-1, 1'b0);
    queue_element(1, 1'b1);
    // ties keep arrival order
    queue_element(5, 1'b0);
    queue_element(5, 1'b0);
    queue_element(-5, 1'b0);
    queue_element(5, 1'b1);
    // fill the store in descending order, then a final item that is dropped
    for (int i = 0; i < MAX_ITEMS; i++) queue_element(MAX_ITEMS - 2 * i, 1'b0);
    queue_element(MOST_NEG, 1'b1);

    // random sets, mostly short, some up to capacity, some over capacity
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19)) inside
        [0:13]:  len = $urandom_range(1, 8);
        [14:16]: len = $urandom_range(9, MAX_ITEMS);
        default: len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
      endcase
      for (int i = 0; i < len; i++) queue_element(draw_value(), i == len - 1);
      total += len;
    end

    // hold reset at start, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for all transactions and results, then a short drain
    @(negedge clk);
    while (element_feed.size() > 0 || start || sorted_expect.size() > 0) @(negedge clk);
    repeat (2 * MAX_ITEMS) @(posedge clk);

    $display("sets sorted: %0d (%0d at capacity, %0d with dropped elements)",
             sets_done, full_sets, overflow_sets);
    $display("results checked: %0d, mismatches: %0d", results_seen, errors);
    if (errors == 0) begin
      $display("insertion_sorter regression: pass");
    end else begin
      $display("insertion_sorter regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/insort_pkg.sv
rtl/insort_cell.sv
rtl/insertion_sorter.sv
tb/insertion_sorter_test.sv
